// ===== src/sync_length_crc_frame_parser_defines.svh =====
// assertion macros for the sync/length/crc frame parser
// used by the top level only; no other dependencies
`ifndef SYNC_LENGTH_CRC_FRAME_PARSER_DEFINES_SVH
`define SYNC_LENGTH_CRC_FRAME_PARSER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication under async active-low reset
`define SLCFP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// next-cycle implication under async active-low reset
`define SLCFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define SLCFP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SLCFP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/slcfp_pkg.sv =====
// shared types, constants and the crc helper for the frame parser
// no dependencies
package slcfp_pkg;

	// default payload capacity and fixed field widths
	localparam int MAX_PAYLOAD_DEF = 32;
	localparam int MIN_LEN         = 2;
	localparam int BYTE_W          = 8;
	localparam int CNT_W           = 6;
	localparam int IDX_W           = 5;
	localparam int CFG_IDX_W       = 8;
	localparam int TDATA_W         = 40;

	// crc-16/ccitt-false
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 8'd1;

	// reset values of the sync registers
	localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
	localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;

	typedef enum logic [2:0] {
		PH_SYNC0,
		PH_SYNC1,
		PH_LEN,
		PH_BODY,
		PH_CRCL,
		PH_CRCH,
		PH_DRAIN
	} phase_t;

	// one byte through the msb-first crc, eight shift steps
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
	                                         input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== src/slcfp_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module slcfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 34
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== src/sync_length_crc_frame_parser.sv =====
// Frame parser: hunts for a two-byte sync pair (a repeated first sync byte is
// tolerated), reads a length byte in 2..2+MAX_PAYLOAD, stores the body bytes
// (type, message id, payload) in a body ram and checks a little-endian
// crc-16/ccitt-false over length and body, one byte per cycle. On a match it
// emits a header result, then one result per payload byte read back from the
// body ram, with tlast on the final result; a mismatch emits nothing. While
// a frame is received the block takes one byte every cycle. After a good
// frame with N payload bytes the input stalls while the payload drains:
// the drain keeps one body-ram read in flight at a time and each read
// waits for the output register to free up, so downstream stalls lengthen
// it. The crc byte completing a frame waits until the output register is
// free. No clearing pass follows reset.
// depends on slcfp_pkg, slcfp_ram and sync_length_crc_frame_parser_defines.svh
`include "sync_length_crc_frame_parser_defines.svh"

module sync_length_crc_frame_parser #(
	parameter int MAX_PAYLOAD = slcfp_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [slcfp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [slcfp_pkg::BYTE_W-1:0]       cfg_data,
	// received bytes
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [slcfp_pkg::BYTE_W-1:0]       s_axis_tdata,  // [7:0] rx_byte
	// results
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [7:0] frame_type, [15:8] message_id, [21:16] payload_count,
	// [26:22] payload_index, [34:27] payload_data, [39:35] zero
	output logic [slcfp_pkg::TDATA_W-1:0]      m_axis_tdata,
	output logic                               m_axis_tuser,  // [0] is_payload
	output logic                               m_axis_tlast
);

	localparam int BODY_DEPTH = MAX_PAYLOAD + slcfp_pkg::MIN_LEN;
	localparam int ADDR_W     = $clog2(BODY_DEPTH);
	localparam int LEN_W      = $clog2(BODY_DEPTH + 1);
	localparam logic [slcfp_pkg::BYTE_W-1:0] MaxLen = slcfp_pkg::BYTE_W'(BODY_DEPTH);
	localparam logic [slcfp_pkg::BYTE_W-1:0] MinLen =
		slcfp_pkg::BYTE_W'(slcfp_pkg::MIN_LEN);

	slcfp_pkg::phase_t phase_q, phase_d;

	logic [slcfp_pkg::BYTE_W-1:0] sync_first_q, sync_second_q;
	logic [LEN_W-1:0]             frame_len_q, body_cnt_q, pay_cnt_q, drain_idx_q;
	logic [15:0]                  crc_q;
	logic [slcfp_pkg::BYTE_W-1:0] crc_low_q, type_q, id_q;

	logic                         rd_s1, rd_last_s1;
	logic [LEN_W-1:0]             rd_idx_s1;
	logic [slcfp_pkg::BYTE_W-1:0] ram_rd_data;

	logic                         out_valid_q, out_isp_q, out_last_q;
	logic [slcfp_pkg::BYTE_W-1:0] out_type_q, out_id_q, out_data_q;
	logic [slcfp_pkg::CNT_W-1:0]  out_cnt_q;
	logic [slcfp_pkg::IDX_W-1:0]  out_idx_q;

	logic                         in_acc, out_free;
	logic                         len_ld, body_wr, crcl_ld, hdr_ld, rd_issue, drain_last;
	logic [LEN_W-1:0]             body_cnt_nx, hdr_cnt;
	logic [7:0]                   b;

	assign b        = s_axis_tdata;
	assign out_free = !out_valid_q || m_axis_tready;
	assign in_acc   = s_axis_tvalid && s_axis_tready;

	// request ready: stalled during drain and until the output slot frees for the crc byte
	always_comb begin
		s_axis_tready = 1'b1;
		if (phase_q == slcfp_pkg::PH_DRAIN) begin
			s_axis_tready = 1'b0;
		end else if (phase_q == slcfp_pkg::PH_CRCH) begin
			s_axis_tready = out_free;
		end
	end

	assign body_cnt_nx = LEN_W'(body_cnt_q + 1'b1);
	assign hdr_cnt     = LEN_W'(frame_len_q - LEN_W'(slcfp_pkg::MIN_LEN));
	assign drain_last  = (LEN_W'(drain_idx_q + 1'b1) == pay_cnt_q);

	// next phase and per-cycle actions
	always_comb begin
		phase_d  = phase_q;
		len_ld   = 1'b0;
		body_wr  = 1'b0;
		crcl_ld  = 1'b0;
		hdr_ld   = 1'b0;
		rd_issue = 1'b0;
		unique case (phase_q)
			slcfp_pkg::PH_SYNC0: begin
				if (in_acc && b == sync_first_q) begin
					phase_d = slcfp_pkg::PH_SYNC1;
				end
			end
			slcfp_pkg::PH_SYNC1: begin
				if (in_acc) begin
					if (b == sync_second_q) begin
						phase_d = slcfp_pkg::PH_LEN;
					end else if (b != sync_first_q) begin
						phase_d = slcfp_pkg::PH_SYNC0;
					end
				end
			end
			slcfp_pkg::PH_LEN: begin
				if (in_acc) begin
					if (b < MinLen || b > MaxLen) begin
						phase_d = slcfp_pkg::PH_SYNC0;
					end else begin
						len_ld  = 1'b1;
						phase_d = slcfp_pkg::PH_BODY;
					end
				end
			end
			slcfp_pkg::PH_BODY: begin
				if (in_acc) begin
					body_wr = 1'b1;
					if (body_cnt_nx >= frame_len_q) begin
						phase_d = slcfp_pkg::PH_CRCL;
					end
				end
			end
			slcfp_pkg::PH_CRCL: begin
				if (in_acc) begin
					crcl_ld = 1'b1;
					phase_d = slcfp_pkg::PH_CRCH;
				end
			end
			slcfp_pkg::PH_CRCH: begin
				if (in_acc) begin
					phase_d = slcfp_pkg::PH_SYNC0;
					if (crc_q == {b, crc_low_q}) begin
						hdr_ld = 1'b1;
						if (hdr_cnt != '0) begin
							phase_d = slcfp_pkg::PH_DRAIN;
						end
					end
				end
			end
			slcfp_pkg::PH_DRAIN: begin
				if (!rd_s1 && out_free) begin
					rd_issue = 1'b1;
					if (drain_last) begin
						phase_d = slcfp_pkg::PH_SYNC0;
					end
				end
			end
			default: begin
				phase_d = slcfp_pkg::PH_SYNC0;
			end
		endcase
	end

	// phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= slcfp_pkg::PH_SYNC0;
		end else begin
			phase_q <= phase_d;
		end
	end

	// configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= slcfp_pkg::SYNC_FIRST_RST;
			sync_second_q <= slcfp_pkg::SYNC_SECOND_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				slcfp_pkg::REG_SYNC_FIRST:  sync_first_q  <= cfg_data;
				slcfp_pkg::REG_SYNC_SECOND: sync_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// frame counters and running crc
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_len_q <= '0;
			body_cnt_q  <= '0;
			crc_q       <= slcfp_pkg::CRC_INIT;
			crc_low_q   <= '0;
		end else begin
			if (len_ld) begin
				frame_len_q <= LEN_W'(b);
				body_cnt_q  <= '0;
				crc_q       <= slcfp_pkg::crc_byte(slcfp_pkg::CRC_INIT, b);
			end
			if (body_wr) begin
				body_cnt_q <= body_cnt_nx;
				crc_q      <= slcfp_pkg::crc_byte(crc_q, b);
			end
			if (crcl_ld) begin
				crc_low_q <= b;
			end
		end
	end

	// type and id held aside for the header and every payload result
	always_ff @(posedge clk) begin
		if (body_wr && body_cnt_q == LEN_W'(0)) begin
			type_q <= b;
		end
		if (body_wr && body_cnt_q == LEN_W'(1)) begin
			id_q <= b;
		end
	end

	// drain counter and payload count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pay_cnt_q   <= '0;
			drain_idx_q <= '0;
		end else begin
			if (hdr_ld) begin
				pay_cnt_q   <= hdr_cnt;
				drain_idx_q <= '0;
			end else if (rd_issue) begin
				drain_idx_q <= LEN_W'(drain_idx_q + 1'b1);
			end
		end
	end

	// body store
	slcfp_ram #(
		.WIDTH (slcfp_pkg::BYTE_W),
		.DEPTH (BODY_DEPTH)
	) u_body_ram (
		.clk     (clk),
		.wr_en   (body_wr),
		.wr_addr (body_cnt_q[ADDR_W-1:0]),
		.wr_data (b),
		.rd_en   (rd_issue),
		.rd_addr (ADDR_W'(drain_idx_q + LEN_W'(slcfp_pkg::MIN_LEN))),
		.rd_data (ram_rd_data)
	);

	// read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= rd_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			rd_idx_s1  <= drain_idx_q;
			rd_last_s1 <= drain_last;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (hdr_ld || rd_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (hdr_ld) begin
			out_isp_q  <= 1'b0;
			out_type_q <= type_q;
			out_id_q   <= id_q;
			out_cnt_q  <= slcfp_pkg::CNT_W'(hdr_cnt);
			out_idx_q  <= '0;
			out_data_q <= '0;
			out_last_q <= (hdr_cnt == '0);
		end else if (rd_s1) begin
			out_isp_q  <= 1'b1;
			out_idx_q  <= slcfp_pkg::IDX_W'(rd_idx_s1);
			out_data_q <= ram_rd_data;
			out_last_q <= rd_last_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_isp_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {5'd0, out_data_q, out_idx_q, out_cnt_q, out_id_q, out_type_q};

	// no input taken while the payload drains
	`SLCFP_ASSERT_IMPLY(a_no_input_in_drain, clk, arst_n,
		phase_q == slcfp_pkg::PH_DRAIN, !s_axis_tready)
	// returning read data always finds the output slot empty
	`SLCFP_ASSERT_IMPLY(a_read_lands_free, clk, arst_n, rd_s1, !out_valid_q)
	// drain index stays inside the payload
	`SLCFP_ASSERT_IMPLY(a_drain_in_range, clk, arst_n,
		phase_q == slcfp_pkg::PH_DRAIN, drain_idx_q < pay_cnt_q)
	// a header always follows a completed crc byte acceptance with a match
	`SLCFP_ASSERT_NEXT(a_hdr_loads_output, clk, arst_n, hdr_ld,
		m_axis_tvalid && !m_axis_tuser)

endmodule

// ===== sim/tb_sync_length_crc_frame_parser.sv =====
// self-checking testbench for the sync/length/crc frame parser: byte streams of good,
// corrupted and truncated frames under random idling, checked against an in-bench parser
// depends on slcfp_pkg and sync_length_crc_frame_parser
`timescale 1ns / 1ps

module tb_sync_length_crc_frame_parser;
	import slcfp_pkg::*;

	localparam int MAX_PAYLOAD = MAX_PAYLOAD_DEF;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 16;
	localparam int END_CYCLES = 100;
	localparam int RUN_LIMIT_NS = 20_000_000;

	typedef enum int {FAULT_NONE, FAULT_CRC, FAULT_LEN, FAULT_CUT} frame_fault_t;

	typedef struct packed {
		logic       is_payload;
		logic [7:0] frame_type;
		logic [7:0] message_id;
		logic [5:0] payload_count;
		logic [4:0] payload_index;
		logic [7:0] payload_data;
		logic       is_last;
	} parsed_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BYTE_W-1:0]    cfg_data = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [BYTE_W-1:0]    s_axis_tdata = '0;  // [7:0] rx_byte
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	// [7:0] frame_type, [15:8] message_id, [21:16] payload_count,
	// [26:22] payload_index, [34:27] payload_data
	logic [TDATA_W-1:0]   m_axis_tdata;
	logic                 m_axis_tuser;  // [0] is_payload
	logic                 m_axis_tlast;

	sync_length_crc_frame_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// 50 MHz clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// stimulus bookkeeping
	logic [7:0]     rx_pending_q[$];
	parsed_result_t frame_results_q[$];
	int             rx_pushed = 0;
	int             rx_accepted = 0;
	int             errors = 0;
	int             send_idle_pct = 0;
	int             recv_stall_pct = 0;
	logic           hold_req = 1'b0;
	int             hold_cnt = 0;

	// parser state mirrored in the bench
	logic [7:0]  cur_sync_first = SYNC_FIRST_RST;
	logic [7:0]  cur_sync_second = SYNC_SECOND_RST;
	phase_t      rx_phase = PH_SYNC0;
	int          frame_len = 0;
	int          body_cnt = 0;
	logic [7:0]  crc_lo = '0;
	logic [15:0] run_crc = CRC_INIT;
	logic [7:0]  body_ram[0:MAX_PAYLOAD+1];

	// bitwise msb-first crc-16/ccitt-false update
	function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ b[i];
			c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
		end
		return c;
	endfunction

	task automatic hunt_restart();
		rx_phase = PH_SYNC0;
		frame_len = 0;
		body_cnt = 0;
		crc_lo = '0;
		run_crc = CRC_INIT;
	endtask

	// queue the header and payload results of a frame that passed its crc
	task automatic emit_frame();
		parsed_result_t r;
		int cnt;
		cnt = frame_len - MIN_LEN;
		r.is_payload = 1'b0;
		r.frame_type = body_ram[0];
		r.message_id = body_ram[1];
		r.payload_count = cnt[5:0];
		r.payload_index = '0;
		r.payload_data = '0;
		r.is_last = (cnt == 0);
		frame_results_q.push_back(r);
		for (int i = 0; i < cnt; i++) begin
			r.is_payload = 1'b1;
			r.payload_index = i[4:0];
			r.payload_data = body_ram[2 + i];
			r.is_last = (i + 1 == cnt);
			frame_results_q.push_back(r);
		end
	endtask

	// advance the mirrored parser by one received byte
	task automatic parse_rx_byte(input logic [7:0] b);
		case (rx_phase)
			PH_SYNC0: begin
				if (b == cur_sync_first)
					rx_phase = PH_SYNC1;
			end
			PH_SYNC1: begin
				// second sync match takes priority when both values are equal
				if (b == cur_sync_second)
					rx_phase = PH_LEN;
				else if (b != cur_sync_first)
					hunt_restart();
			end
			PH_LEN: begin
				if (b < MIN_LEN || b > MIN_LEN + MAX_PAYLOAD) begin
					hunt_restart();
				end else begin
					frame_len = int'(b);
					body_cnt = 0;
					run_crc = crc_next(CRC_INIT, b);
					rx_phase = PH_BODY;
				end
			end
			PH_BODY: begin
				body_ram[body_cnt] = b;
				body_cnt++;
				run_crc = crc_next(run_crc, b);
				if (body_cnt >= frame_len)
					rx_phase = PH_CRCL;
			end
			PH_CRCL: begin
				crc_lo = b;
				rx_phase = PH_CRCH;
			end
			PH_CRCH: begin
				if (run_crc == {b, crc_lo})
					emit_frame();
				hunt_restart();
			end
			default: begin
				hunt_restart();
			end
		endcase
	endtask

	// input driver: one request per accepted byte, random gaps between them
	always @(posedge clk) begin : rx_driver
		logic taken;
		taken = s_axis_tvalid && s_axis_tready;
		if (taken) begin
			parse_rx_byte(s_axis_tdata);
			rx_accepted++;
		end
		if (!s_axis_tvalid || taken) begin
			if (rx_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= rx_pending_q.pop_front();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// long receiver hold-off counter
	always @(posedge clk) begin
		if (hold_req)
			hold_cnt <= HOLD_CYCLES;
		else if (hold_cnt != 0)
			hold_cnt <= hold_cnt - 1;
	end

	task automatic cmp_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// result monitor and receiver stalls
	always @(posedge clk) begin : result_monitor
		parsed_result_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (frame_results_q.size() == 0) begin
				$error("unexpected result: tdata %h tuser %b tlast %b",
					m_axis_tdata, m_axis_tuser, m_axis_tlast);
				errors++;
			end else begin
				want = frame_results_q.pop_front();
				cmp_field("is_payload", int'(want.is_payload), int'(m_axis_tuser));
				cmp_field("frame_type", int'(want.frame_type), int'(m_axis_tdata[7:0]));
				cmp_field("message_id", int'(want.message_id), int'(m_axis_tdata[15:8]));
				cmp_field("payload_count", int'(want.payload_count),
					int'(m_axis_tdata[21:16]));
				cmp_field("payload_index", int'(want.payload_index),
					int'(m_axis_tdata[26:22]));
				cmp_field("payload_data", int'(want.payload_data),
					int'(m_axis_tdata[34:27]));
				cmp_field("last", int'(want.is_last), int'(m_axis_tlast));
			end
		end
		m_axis_tready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic push_rx(input logic [7:0] b);
		rx_pending_q.push_back(b);
		rx_pushed++;
	endtask

	// build one frame with the current sync pair, optionally damaged
	task automatic push_frame(input logic [7:0] typ, input logic [7:0] id, input int n,
		input frame_fault_t fault, input bit dup_sync);
		logic [7:0]  fb[$];
		logic [7:0]  b;
		logic [15:0] crc;
		int          keep;
		if (dup_sync)
			fb.push_back(cur_sync_first);
		fb.push_back(cur_sync_first);
		fb.push_back(cur_sync_second);
		if (fault == FAULT_LEN) begin
			fb.push_back($urandom_range(1) ? 8'($urandom_range(1))
				: 8'($urandom_range(255, MIN_LEN + MAX_PAYLOAD + 1)));
			repeat (n) fb.push_back(8'($urandom_range(255)));
		end else begin
			crc = crc_next(CRC_INIT, 8'(n + MIN_LEN));
			fb.push_back(8'(n + MIN_LEN));
			for (int i = 0; i < n + MIN_LEN; i++) begin
				b = (i == 0) ? typ : (i == 1) ? id : 8'($urandom_range(255));
				crc = crc_next(crc, b);
				fb.push_back(b);
			end
			if (fault == FAULT_CRC)
				crc ^= 16'(1 << $urandom_range(15));
			fb.push_back(crc[7:0]);
			fb.push_back(crc[15:8]);
		end
		keep = (fault == FAULT_CUT) ? $urandom_range(fb.size() - 2, 3) : fb.size();
		for (int i = 0; i < keep; i++)
			push_rx(fb[i]);
	endtask

	// mostly well-formed frames with random content, the rest damage and noise
	task automatic push_random_traffic(input int budget);
		int start;
		int r;
		int n;
		start = rx_pushed;
		while (rx_pushed - start < budget) begin
			r = $urandom_range(99);
			n = ($urandom_range(9) == 0) ? $urandom_range(MAX_PAYLOAD) : $urandom_range(8);
			if (r < 70)
				push_frame(8'($urandom_range(255)), 8'($urandom_range(255)), n,
					FAULT_NONE, $urandom_range(7) == 0);
			else if (r < 80)
				push_frame(8'($urandom_range(255)), 8'($urandom_range(255)), n,
					FAULT_CRC, 1'b0);
			else if (r < 87)
				push_frame(8'h00, 8'h00, $urandom_range(3), FAULT_LEN, 1'b0);
			else if (r < 93)
				push_frame(8'($urandom_range(255)), 8'($urandom_range(255)), n,
					FAULT_CUT, 1'b0);
			else
				repeat ($urandom_range(4, 1)) push_rx(8'($urandom_range(255)));
		end
	endtask

	// sender pauses until every byte is taken and every result has come
	task automatic wait_idle();
		do @(posedge clk);
		while (rx_accepted != rx_pushed || frame_results_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write both sync registers back to back on the config channel
	task automatic write_syncs(input logic [7:0] f, input logic [7:0] s);
		cfg_valid <= 1'b1;
		cfg_index <= REG_SYNC_FIRST;
		cfg_data <= f;
		do @(posedge clk);
		while (!cfg_ready);
		cur_sync_first = f;
		cfg_index <= REG_SYNC_SECOND;
		cfg_data <= s;
		do @(posedge clk);
		while (!cfg_ready);
		cur_sync_second = s;
		cfg_valid <= 1'b0;
	endtask

	// run sequence
	initial begin : stimulus
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: noise extremes, repeated first sync with empty payload,
		// length below and above range, crc mismatch
		push_rx(8'h00);
		push_rx(8'hFF);
		push_frame(8'hFF, 8'h00, 0, FAULT_NONE, 1'b1);
		push_rx(cur_sync_first);
		push_rx(cur_sync_second);
		push_rx(8'(MIN_LEN - 1));
		push_rx(cur_sync_first);
		push_rx(cur_sync_second);
		push_rx(8'(MIN_LEN + MAX_PAYLOAD + 1));
		push_frame(8'h00, 8'hFF, 0, FAULT_CRC, 1'b0);
		wait_idle();

		// receiver holds off while long frames keep coming
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		push_frame(8'($urandom_range(255)), 8'($urandom_range(255)), MAX_PAYLOAD,
			FAULT_NONE, 1'b0);
		push_frame(8'($urandom_range(255)), 8'($urandom_range(255)), 0, FAULT_NONE, 1'b0);
		push_frame(8'($urandom_range(255)), 8'($urandom_range(255)), MAX_PAYLOAD - 1,
			FAULT_NONE, 1'b0);
		push_frame(8'($urandom_range(255)), 8'($urandom_range(255)), MAX_PAYLOAD,
			FAULT_NONE, 1'b0);
		push_frame(8'($urandom_range(255)), 8'($urandom_range(255)), 1, FAULT_NONE, 1'b0);
		push_frame(8'($urandom_range(255)), 8'($urandom_range(255)), 17, FAULT_NONE, 1'b0);
		wait_idle();

		// random traffic under several sync settings and idling mixes
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: write_syncs(8'h00, 8'hFF);
				1: write_syncs(8'hFF, 8'h00);
				2: write_syncs(8'h04, 8'h04);
				3: write_syncs(8'($urandom_range(255)), 8'($urandom_range(255)));
				default: write_syncs(SYNC_FIRST_RST, SYNC_SECOND_RST);
			endcase
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 75;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 75;
				end
				default: begin
					send_idle_pct = 21;
					recv_stall_pct = 21;
				end
			endcase
			push_random_traffic(70);
			wait_idle();
		end

		repeat (END_CYCLES) @(posedge clk);
		if (errors == 0 && frame_results_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// run limit
	initial begin
		#(RUN_LIMIT_NS);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
